### rtl/mcss_pkg.sv
// Shared widths, register codes, control types and the cosine table function.
package mcss_pkg;

  localparam int unsigned MCSS_PHASE_BITS     = 32;
  localparam int unsigned MCSS_COS_TABLE_BITS = 10;

  localparam int unsigned FreqW    = 32;
  localparam int unsigned BgW      = 16;
  localparam int unsigned AmpW     = 15;
  localparam int unsigned NoiseW   = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned PhaseOutW = 32;
  localparam int unsigned StartW   = 32;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned CosW     = 15;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SDataW   = 80;
  localparam int unsigned MDataW   = 48;

  localparam logic [DepthW-1:0] DepthStepReset = 16'd256;
  localparam logic [63:0]       HalfPiQ31      = 64'hC90FDAA2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartPhase,
    CfgDepthStep
  } cfg_idx_e;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic phase;
    logic rom;
    logic prod;
    logic out_load;
  } cmd_t;

  // Quarter-wave cosine entry in unsigned Q0.15, built by an integer Taylor series in Q30.
  function automatic logic [CosW-1:0] cos_entry(input int unsigned k, input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (64'(k) * HalfPiQ31 + (64'd1 << tbits)) >> (tbits + 1);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    for (int unsigned n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (64'(sum) + (64'd1 << 14)) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[CosW-1:0];
  endfunction

endpackage

### rtl/mcss_ctrl.sv
// Sequencing state machine and output word valid for the cosine synthesizer.
module mcss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mcss_pkg::cmd_t cmd_o
);
  import mcss_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StPhase,
    StRom,
    StProd,
    StSum
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StPhase;
      end
      StPhase: begin
        cmd_o.phase = 1'b1;
        state_d     = StRom;
      end
      StRom: begin
        cmd_o.rom = 1'b1;
        state_d   = StProd;
      end
      StProd: begin
        cmd_o.prod = 1'b1;
        state_d    = StSum;
      end
      StSum: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result word loaded over a pending word");

  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd_o.mul)
    else $error("accepted word did not enter the multiply step");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_in, cmd_o.mul, cmd_o.phase, cmd_o.rom, cmd_o.prod, cmd_o.out_load}))
    else $error("more than one datapath step in one cycle");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_o && in_ready_o))
    else $error("loaded result not presented or controller not idle");

endmodule

### rtl/mcss_dp.sv
// Datapath: configuration registers, phase accumulator, cosine table and output sum.
module mcss_dp #(
  parameter int unsigned PHASE_BITS     = mcss_pkg::MCSS_PHASE_BITS,
  parameter int unsigned COS_TABLE_BITS = mcss_pkg::MCSS_COS_TABLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mcss_pkg::CfgDataW-1:0]     cfg_data_i,
  input  mcss_pkg::cmd_t                    cmd_i,
  input  logic                              first_sample_i,
  input  logic [mcss_pkg::FreqW-1:0]        frequency_i,
  input  logic signed [mcss_pkg::BgW-1:0]   background_i,
  input  logic [mcss_pkg::AmpW-1:0]         amplitude_i,
  input  logic signed [mcss_pkg::NoiseW-1:0] noise_i,
  output logic signed [mcss_pkg::SampleW-1:0] sample_o,
  output logic                              saturated_o,
  output logic [mcss_pkg::PhaseOutW-1:0]    phase_out_o
);
  import mcss_pkg::*;

  localparam int unsigned ProdW      = FreqW + DepthW;
  localparam int unsigned IncExtW    = ProdW + 8;
  localparam int unsigned IncLsb     = 48 - PHASE_BITS;
  localparam int unsigned TabEntries = (1 << COS_TABLE_BITS) + 1;
  localparam logic [COS_TABLE_BITS:0] TabN = {1'b1, {COS_TABLE_BITS{1'b0}}};

  logic [StartW-1:0]         start_phase_q;
  logic [DepthW-1:0]         depth_step_q;
  logic [PHASE_BITS-1:0]     acc_q;
  logic [PHASE_BITS-1:0]     inc_q;
  logic                      first_q;
  logic [FreqW-1:0]          freq_q;
  logic signed [BgW-1:0]     bg_q;
  logic [AmpW-1:0]           amp_q;
  logic signed [NoiseW-1:0]  nz_q;
  logic [CosW-1:0]           cos_mag_q;
  logic                      neg_q;
  logic signed [31:0]        prod_q;
  logic signed [SampleW-1:0] sample_q;
  logic                      sat_q;
  logic [PhaseOutW-1:0]      phase_out_q;

  logic [ProdW-1:0]               mul_full;
  logic [IncExtW-1:0]             inc_ext;
  logic [47:0]                    start_ext;
  logic [PHASE_BITS-1:0]          start_ph;
  logic [PHASE_BITS+31:0]         ph_ext;
  logic [PhaseOutW-1:0]           p32;
  logic [1:0]                     quad;
  logic [COS_TABLE_BITS-1:0]      idx;
  logic [COS_TABLE_BITS:0]        rom_addr;
  logic [CosW-1:0]                cos_rom [TabEntries];
  logic signed [15:0]             cos_s;
  logic signed [31:0]             rnd;
  logic signed [16:0]             scaled;
  logic signed [18:0]             sum;
  logic signed [SampleW-1:0]      sum_sat;
  logic                           sum_clip;

  for (genvar k = 0; k < TabEntries; k++) begin : g_cos_rom
    if (k == TabEntries - 1) begin : g_last
      assign cos_rom[k] = '0;
    end else begin : g_entry
      assign cos_rom[k] = cos_entry(k, COS_TABLE_BITS);
    end
  end

  assign mul_full  = freq_q * depth_step_q;
  assign inc_ext   = {mul_full, 8'b0};
  assign start_ext = {start_phase_q, 16'b0};
  assign start_ph  = start_ext[IncLsb +: PHASE_BITS];
  assign ph_ext    = {acc_q, 32'b0};
  assign p32       = ph_ext[PHASE_BITS +: PhaseOutW];
  assign quad      = p32[31:30];
  assign idx       = p32[29 -: COS_TABLE_BITS];
  assign rom_addr  = quad[0] ? (TabN - {1'b0, idx}) : {1'b0, idx};

  assign cos_s  = neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});
  assign rnd    = prod_q + 32'sd16384;
  assign scaled = rnd[31:15];
  assign sum    = 19'(bg_q) + 19'(scaled) + 19'(nz_q);

  always_comb begin
    sum_clip = 1'b0;
    sum_sat  = sum[SampleW-1:0];
    if (sum > 19'sd32767) begin
      sum_sat  = 16'sh7FFF;
      sum_clip = 1'b1;
    end else if (sum < -19'sd32768) begin
      sum_sat  = 16'sh8000;
      sum_clip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_phase_q <= '0;
      depth_step_q  <= DepthStepReset;
      acc_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgStartPhase: start_phase_q <= cfg_data_i[StartW-1:0];
          CfgDepthStep:  depth_step_q  <= cfg_data_i[DepthW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.phase) begin
        acc_q <= first_q ? start_ph : acc_q + inc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      first_q <= first_sample_i;
      freq_q  <= frequency_i;
      bg_q    <= background_i;
      amp_q   <= amplitude_i;
      nz_q    <= noise_i;
    end
    if (cmd_i.mul) begin
      inc_q <= inc_ext[IncLsb +: PHASE_BITS];
    end
    if (cmd_i.rom) begin
      cos_mag_q <= cos_rom[rom_addr];
      neg_q     <= quad[0] ^ quad[1];
    end
    if (cmd_i.prod) begin
      prod_q <= $signed({1'b0, amp_q}) * cos_s;
    end
    if (cmd_i.out_load) begin
      sample_q    <= sum_sat;
      sat_q       <= sum_clip;
      phase_out_q <= p32;
    end
  end

  assign sample_o    = sample_q;
  assign saturated_o = sat_q;
  assign phase_out_o = phase_out_q;

endmodule

### rtl/modulated_cosine_signal_synth_core.sv
// Top level of the modulated cosine sample synthesizer.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: frequency, background, amplitude, noise; tuser: first_sample
//   m_axis   out        tdata: sample, phase_out; tuser: saturated
//   cfg      in         cfg_index_i selects start_phase (0) or depth_step (1)
//
// A word's result is loaded into the output register after the controller steps through
// multiply, phase add, table read, amplitude multiply and saturating sum, one step at a time.
// A new word is taken only when the controller is idle again, after the last result is loaded.
// A stalled output holds the controller in its final step until the output register frees.
// Reset clears the phase accumulator and loads start_phase 0 and depth_step 1.0.
module modulated_cosine_signal_synth_core #(
  parameter int unsigned PHASE_BITS     = mcss_pkg::MCSS_PHASE_BITS,
  parameter int unsigned COS_TABLE_BITS = mcss_pkg::MCSS_COS_TABLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // frequency[31:0], background[47:32], amplitude[62:48], noise[78:63], unused[79]
  input  logic [mcss_pkg::SDataW-1:0]   s_axis_tdata,
  // first_sample[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample[15:0], phase_out[47:16]
  output logic [mcss_pkg::MDataW-1:0]   m_axis_tdata,
  // saturated[0]
  output logic                          m_axis_tuser
);
  import mcss_pkg::*;

  cmd_t                      cmd;
  logic signed [SampleW-1:0] sample;
  logic [PhaseOutW-1:0]      phase_out;

  mcss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mcss_dp #(
    .PHASE_BITS     (PHASE_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .first_sample_i (s_axis_tuser),
    .frequency_i    (s_axis_tdata[31:0]),
    .background_i   (s_axis_tdata[47:32]),
    .amplitude_i    (s_axis_tdata[62:48]),
    .noise_i        (s_axis_tdata[78:63]),
    .sample_o       (sample),
    .saturated_o    (m_axis_tuser),
    .phase_out_o    (phase_out)
  );

  assign m_axis_tdata = {phase_out, sample};

endmodule
